FILE: rtl/grc_pkg.sv
package grc_pkg;

    localparam int GRID_W_DEF = 64;
    localparam int GRID_H_DEF = 64;
    localparam int WALK_EXTRA = 130;
    localparam int COORD_W    = 10;
    localparam int DIV_NUM_W  = 40;
    localparam int DIV_DEN_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

    localparam logic [7:0] RED_R  = 8'd230;
    localparam logic [7:0] RED_G  = 8'd41;
    localparam logic [7:0] RED_B  = 8'd55;
    localparam logic [7:0] BLUE_R = 8'd0;
    localparam logic [7:0] BLUE_G = 8'd121;
    localparam logic [7:0] BLUE_B = 8'd241;
    localparam logic [7:0] CODE_RED = 8'd1;

    typedef enum logic [2:0] {
        CFG_VIEWER_X, CFG_VIEWER_Y, CFG_FACING_X, CFG_FACING_Y,
        CFG_PLANE_DX, CFG_PLANE_DY, CFG_SCREEN_W, CFG_SCREEN_H
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIV_CAM, DIV_DX, DIV_DY, DIV_DIST, DIV_LH
    } t_div_sel;

    typedef struct packed {
        logic        action;
        logic [5:0]  cell_x;
        logic [5:0]  cell_y;
        logic [7:0]  cell_value;
        logic [10:0] column;
    } t_in_item;

    typedef struct packed {
        logic [10:0] out_column;
        logic        hit;
        logic [10:0] span_top;
        logic [10:0] span_bottom;
        logic        side_hit;
        logic [7:0]  wall_code;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue_level;
    } t_out_item;

    typedef struct packed {
        logic     clear_wr;
        logic     cell_wr;
        logic     take_item;
        logic     div_start;
        t_div_sel div_sel;
        logic     mul_ray;
        logic     ray_sum;
        logic     side_mul;
        logic     side_init;
        logic     walk_step;
        logic     dist_prep;
        logic     load_out;
        logic     out_hit;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic div_done;
        logic out_of_map;
        logic cell_nonzero;
        logic walk_last;
    } t_sts;

    // Saturate a wide quotient to unsigned Q16.16.
    function automatic logic [31:0] sat32(input logic [DIV_NUM_W-1:0] v);
        return (|v[DIV_NUM_W-1:32]) ? DIST_MAX : v[31:0];
    endfunction

endpackage

FILE: rtl/grid_raycast_column_core.sv
// Grid ray caster, one screen column per cast item. The block keeps a
// GRID_W x GRID_H map of 8-bit wall codes. A write item (action 0) stores
// one cell; cells outside the map are dropped. A cast item (action 1) forms
// the ray for its column from the configured viewer, facing vector and
// camera plane, walks the map cell by cell until it meets a nonzero code,
// and returns the clamped wall stripe, side and colour, or hit=0 when the
// ray leaves the map or its walk limit runs out. After reset the input
// stalls while a sweep clears the map; configuration writes are taken
// during that sweep as at any time. A cast that hits holds the input until
// its result is loaded: five divisions (start, 40 quotient bits, done) on
// the one shared serial divider (camera coordinate, two reciprocals, wall
// distance, line height), setup and hand-off, and per walk step a step, a
// registered map read and a check. A ray that leaves the map skips the last
// two divisions. A finished result waits in the output register while the
// next item is taken.
module grid_raycast_column_core #(
    parameter int GRID_W = grc_pkg::GRID_W_DEF,
    parameter int GRID_H = grc_pkg::GRID_H_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  grc_pkg::t_in_item              i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output grc_pkg::t_out_item             o_out,
    input  logic                           i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import grc_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencing: clear sweep, divisions, walk, result hand-off
    grc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_cast  (i_in.action),
        .i_out_stall(i_out_stall),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .o_cmd      (w_cmd)
    );

    // configuration, map store, ray arithmetic and the result register
    grc_datapath #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_sts      (w_sts),
        .o_out      (o_out)
    );

    // a hit always carries a nonzero wall code
    a_hit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.hit |-> o_out.wall_code != 8'd0)
        else $error("hit result with empty wall code");

    // a miss carries nothing but its column
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.hit |-> o_out.span_top == 11'd0 &&
        o_out.span_bottom == 11'd0 && o_out.red == 8'd0 &&
        o_out.green == 8'd0 && o_out.blue_level == 8'd0)
        else $error("miss result with nonzero fields");

    // the stripe never inverts
    a_span_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.hit |-> o_out.span_top <= o_out.span_bottom)
        else $error("stripe top below bottom");

    // the input is stalled right after reset, as the map sweep begins
    a_clear_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during map clear");
endmodule

FILE: rtl/grc_ram.sv
module grc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/grc_div.sv
module grc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [grc_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [grc_pkg::DIV_DEN_W-1:0]  i_den,
    output logic                           o_done,
    output logic [grc_pkg::DIV_NUM_W-1:0]  o_quot
);
    import grc_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy, r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_NUM_W-1:0] r_q;
    logic [DIV_DEN_W-1:0] r_rem, r_den;
    logic [DIV_DEN_W:0]   w_sh;
    logic                 w_ge;

    // One quotient bit per cycle; a zero divisor yields all ones.
    assign w_sh = {r_rem, r_q[DIV_NUM_W-1]};
    assign w_ge = w_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? DIV_DEN_W'(w_sh - {1'b0, r_den}) : w_sh[DIV_DEN_W-1:0];
            r_q   <= {r_q[DIV_NUM_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: rtl/grc_datapath.sv
module grc_datapath #(
    parameter int GRID_W = grc_pkg::GRID_W_DEF,
    parameter int GRID_H = grc_pkg::GRID_H_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  grc_pkg::t_cmd                  i_cmd,
    input  grc_pkg::t_in_item              i_in,
    input  logic                           i_cfg_we,
    input  logic [grc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output grc_pkg::t_sts                  o_sts,
    output grc_pkg::t_out_item             o_out
);
    import grc_pkg::*;

    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LIMIT  = GRID_W + GRID_H + WALK_EXTRA;
    localparam int CNT_W  = $clog2(LIMIT + 1);

    // configuration
    logic [15:0]        r_viewer_x, r_viewer_y;
    logic signed [15:0] r_facing_x, r_facing_y, r_plane_dx, r_plane_dy;
    logic [11:0]        r_w, r_h;
    logic [11:0]        w_clamped;

    // working registers
    logic [10:0]               r_column;
    logic signed [27:0]        r_cam;
    logic signed [43:0]        r_prod_x, r_prod_y;
    logic signed [29:0]        r_rx, r_ry;
    logic [31:0]               r_dx, r_dy, r_sx, r_sy, r_dist;
    logic [42:0]               r_px, r_py;
    logic signed [COORD_W-1:0] r_mx, r_my;
    logic                      r_side;
    logic [CNT_W-1:0]          r_cnt;
    logic [7:0]                r_code;
    logic [19:0]               r_num_mag;
    logic [11:0]               r_lh;
    logic [ADDR_W-1:0]         r_clr_addr;
    t_div_sel                  r_div_sel;
    t_out_item                 r_out;

    logic [29:0]          w_mag_x, w_mag_y;
    logic [DIV_NUM_W-1:0] w_num, w_quot;
    logic [DIV_DEN_W-1:0] w_den;
    logic                 w_div_done;
    logic [10:0]          w_frac_x, w_frac_y;
    logic [32:0]          w_sum_x, w_sum_y;
    logic signed [20:0]   w_num_s;
    logic [11:0]          w_half, w_hl, w_bot;
    logic [7:0]           w_r, w_g, w_b;
    logic                 w_we, w_cell_ok;
    logic [ADDR_W-1:0]    w_waddr, w_raddr;
    logic [7:0]           w_wdata, w_rdata;
    t_out_item            w_out;

    // Screen sizes use the low 12 bits: zero acts as one, above 2048 acts as 2048.
    assign w_clamped = (i_cfg_data[11:0] == 12'd0) ? 12'd1 :
                       (i_cfg_data[11:0] > 12'd2048) ? 12'd2048 : i_cfg_data[11:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viewer_x <= 16'd32768;
            r_viewer_y <= 16'd32768;
            r_facing_x <= -16'sd16384;
            r_facing_y <= 16'sd0;
            r_plane_dx <= 16'sd0;
            r_plane_dy <= 16'sd10813;
            r_w        <= 12'd640;
            r_h        <= 12'd480;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_VIEWER_X: r_viewer_x <= i_cfg_data;
                CFG_VIEWER_Y: r_viewer_y <= i_cfg_data;
                CFG_FACING_X: r_facing_x <= $signed(i_cfg_data);
                CFG_FACING_Y: r_facing_y <= $signed(i_cfg_data);
                CFG_PLANE_DX: r_plane_dx <= $signed(i_cfg_data);
                CFG_PLANE_DY: r_plane_dy <= $signed(i_cfg_data);
                CFG_SCREEN_W: r_w        <= w_clamped;
                CFG_SCREEN_H: r_h        <= w_clamped;
            endcase
        end
    end

    // divider operand select
    assign w_mag_x = r_rx[29] ? 30'(-r_rx) : 30'(r_rx);
    assign w_mag_y = r_ry[29] ? 30'(-r_ry) : 30'(r_ry);

    always_comb begin
        case (i_cmd.div_sel)
            DIV_CAM: begin
                w_num = DIV_NUM_W'({r_column, 15'd0});
                w_den = DIV_DEN_W'(r_w);
            end
            DIV_DX: begin
                w_num = DIV_NUM_W'(1) << 30;
                w_den = DIV_DEN_W'(w_mag_x);
            end
            DIV_DY: begin
                w_num = DIV_NUM_W'(1) << 30;
                w_den = DIV_DEN_W'(w_mag_y);
            end
            DIV_DIST: begin
                w_num = {r_num_mag, 20'd0};
                w_den = r_side ? DIV_DEN_W'(w_mag_y) : DIV_DEN_W'(w_mag_x);
            end
            default: begin
                w_num = DIV_NUM_W'({r_h, 16'd0});
                w_den = r_dist;
            end
        endcase
    end

    grc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_cmd.div_start),
        .i_num  (w_num),
        .i_den  (w_den),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign w_frac_x = r_rx[29] ? {1'b0, r_viewer_x[9:0]} : 11'd1024 - {1'b0, r_viewer_x[9:0]};
    assign w_frac_y = r_ry[29] ? {1'b0, r_viewer_y[9:0]} : 11'd1024 - {1'b0, r_viewer_y[9:0]};
    assign w_sum_x  = {1'b0, r_sx} + {1'b0, r_dx};
    assign w_sum_y  = {1'b0, r_sy} + {1'b0, r_dy};

    // Distance from viewer to the crossed edge, Q10.
    assign w_num_s = r_side ?
        (21'(r_my) * 21'sd1024) - $signed({5'd0, r_viewer_y}) + (r_ry[29] ? 21'sd1024 : 21'sd0) :
        (21'(r_mx) * 21'sd1024) - $signed({5'd0, r_viewer_x}) + (r_rx[29] ? 21'sd1024 : 21'sd0);

    // result item: column always, the rest only on a hit
    always_comb begin
        w_out = '0;
        w_out.out_column = r_column;
        if (i_cmd.out_hit) begin
            w_out.hit         = 1'b1;
            w_out.span_top    = 11'(w_half - w_hl);
            w_out.span_bottom = 11'(w_bot);
            w_out.side_hit    = r_side;
            w_out.wall_code   = r_code;
            w_out.red         = w_r;
            w_out.green       = w_g;
            w_out.blue_level  = w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_column <= i_in.column;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
        end
        if (w_div_done) begin
            case (r_div_sel)
                DIV_CAM:  r_cam  <= $signed({2'b00, w_quot[25:0]}) - 28'sd16384;
                DIV_DX:   r_dx   <= sat32(w_quot);
                DIV_DY:   r_dy   <= sat32(w_quot);
                DIV_DIST: r_dist <= sat32(w_quot);
                default:  r_lh   <= (w_quot > DIV_NUM_W'(r_h)) ? r_h : w_quot[11:0];
            endcase
        end
        if (i_cmd.mul_ray) begin
            r_prod_x <= r_plane_dx * r_cam;
            r_prod_y <= r_plane_dy * r_cam;
        end
        if (i_cmd.ray_sum) begin
            r_rx <= 30'(r_facing_x) + 30'(r_prod_x >>> 14);
            r_ry <= 30'(r_facing_y) + 30'(r_prod_y >>> 14);
        end
        if (i_cmd.side_mul) begin
            r_px <= w_frac_x * r_dx;
            r_py <= w_frac_y * r_dy;
        end
        if (i_cmd.side_init) begin
            r_sx   <= sat32(DIV_NUM_W'(r_px >> 10));
            r_sy   <= sat32(DIV_NUM_W'(r_py >> 10));
            r_mx   <= $signed(COORD_W'(r_viewer_x[15:10]));
            r_my   <= $signed(COORD_W'(r_viewer_y[15:10]));
            r_side <= 1'b0;
            r_cnt  <= '0;
        end else if (i_cmd.walk_step) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_sx < r_sy) begin
                r_sx   <= w_sum_x[32] ? DIST_MAX : w_sum_x[31:0];
                r_mx   <= r_rx[29] ? r_mx - COORD_W'(1) : r_mx + COORD_W'(1);
                r_side <= 1'b0;
            end else begin
                r_sy   <= w_sum_y[32] ? DIST_MAX : w_sum_y[31:0];
                r_my   <= r_ry[29] ? r_my - COORD_W'(1) : r_my + COORD_W'(1);
                r_side <= 1'b1;
            end
        end
        r_code <= w_rdata;
        if (i_cmd.dist_prep) begin
            r_num_mag <= w_num_s[20] ? 20'(-w_num_s) : 20'(w_num_s);
        end
        if (i_cmd.load_out) begin
            r_out <= w_out;
        end
    end

    // stripe span and colour
    assign w_half = r_h >> 1;
    assign w_hl   = r_lh >> 1;
    assign w_bot  = (w_half + w_hl > r_h - 12'd1) ? r_h - 12'd1 : w_half + w_hl;
    assign w_r    = (r_code == CODE_RED) ? (r_side ? RED_R >> 1 : RED_R) :
                                           (r_side ? BLUE_R >> 1 : BLUE_R);
    assign w_g    = (r_code == CODE_RED) ? (r_side ? RED_G >> 1 : RED_G) :
                                           (r_side ? BLUE_G >> 1 : BLUE_G);
    assign w_b    = (r_code == CODE_RED) ? (r_side ? RED_B >> 1 : RED_B) :
                                           (r_side ? BLUE_B >> 1 : BLUE_B);

    // map store: clearing sweep, cell writes, walk reads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    assign w_cell_ok = (32'(i_in.cell_x) < 32'(GRID_W)) && (32'(i_in.cell_y) < 32'(GRID_H));
    assign w_we      = i_cmd.clear_wr || (i_cmd.cell_wr && w_cell_ok);
    assign w_waddr   = i_cmd.clear_wr ? r_clr_addr :
                       ADDR_W'(32'(i_in.cell_x) * 32'(GRID_H) + 32'(i_in.cell_y));
    assign w_wdata   = i_cmd.clear_wr ? 8'd0 : i_in.cell_value;
    assign w_raddr   = ADDR_W'(32'(r_mx[COORD_W-2:0]) * 32'(GRID_H) +
                               32'(r_my[COORD_W-2:0]));

    grc_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_map (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign o_sts.clear_last   = r_clr_addr == ADDR_W'(DEPTH - 1);
    assign o_sts.div_done     = w_div_done;
    assign o_sts.out_of_map   = r_mx[COORD_W-1] || r_my[COORD_W-1] ||
                                (32'(r_mx) >= 32'(GRID_W)) || (32'(r_my) >= 32'(GRID_H));
    assign o_sts.cell_nonzero = w_rdata != 8'd0;
    assign o_sts.walk_last    = r_cnt == CNT_W'(LIMIT);
    assign o_out              = r_out;
endmodule

FILE: rtl/grc_ctrl.sv
module grc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_cast,
    input  logic          i_out_stall,
    input  grc_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output grc_pkg::t_cmd o_cmd
);
    import grc_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CAM_GO, S_CAM_WAIT, S_MUL, S_RAY,
        S_DX_GO, S_DX_WAIT, S_DY_GO, S_DY_WAIT, S_SIDE_MUL, S_SIDE_INIT,
        S_STEP, S_READ, S_CHECK, S_DIST_PREP, S_DIST_GO, S_DIST_WAIT,
        S_LH_GO, S_LH_WAIT, S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_hit, n_hit;
    logic   r_out_valid, n_out_valid;
    logic   w_accept, w_load;

    assign w_accept = i_in_valid && (r_state == S_IDLE);
    assign w_load   = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        o_cmd   = '0;
        o_cmd.div_sel = DIV_CAM;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.cell_wr   = w_accept && !i_in_cast;
                o_cmd.take_item = w_accept && i_in_cast;
                if (w_accept && i_in_cast) n_state = S_CAM_GO;
            end
            S_CAM_GO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_CAM_WAIT;
            end
            S_CAM_WAIT: if (i_sts.div_done) n_state = S_MUL;
            S_MUL: begin
                o_cmd.mul_ray = 1'b1;
                n_state = S_RAY;
            end
            S_RAY: begin
                o_cmd.ray_sum = 1'b1;
                n_state = S_DX_GO;
            end
            S_DX_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_DX;
                n_state = S_DX_WAIT;
            end
            S_DX_WAIT: if (i_sts.div_done) n_state = S_DY_GO;
            S_DY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_DY;
                n_state = S_DY_WAIT;
            end
            S_DY_WAIT: if (i_sts.div_done) n_state = S_SIDE_MUL;
            S_SIDE_MUL: begin
                o_cmd.side_mul = 1'b1;
                n_state = S_SIDE_INIT;
            end
            S_SIDE_INIT: begin
                o_cmd.side_init = 1'b1;
                n_state = S_STEP;
            end
            S_STEP: begin
                o_cmd.walk_step = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                if (i_sts.out_of_map) begin
                    n_hit   = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.cell_nonzero) begin
                    n_hit   = 1'b1;
                    n_state = S_DIST_PREP;
                end else if (i_sts.walk_last) begin
                    n_hit   = 1'b0;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_DIST_PREP: begin
                o_cmd.dist_prep = 1'b1;
                n_state = S_DIST_GO;
            end
            S_DIST_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_DIST;
                n_state = S_DIST_WAIT;
            end
            S_DIST_WAIT: if (i_sts.div_done) n_state = S_LH_GO;
            S_LH_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_LH;
                n_state = S_LH_WAIT;
            end
            S_LH_WAIT: if (i_sts.div_done) n_state = S_FINISH;
            S_FINISH: begin
                o_cmd.load_out = w_load;
                o_cmd.out_hit  = r_hit;
                if (w_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) n_out_valid = 1'b0;
        if (w_load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
endmodule
